// ----- design/srt_pkg.sv -----
package srt_pkg;

  localparam int DATA_W        = 32;
  localparam int PIX_W         = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Full-width product of two DATA_W operands.
  localparam int PROD_W = 2 * DATA_W;
  // Four products and a scaled translation summed without overflow.
  localparam int SUM_W  = PROD_W + 3;

  localparam logic [PIX_W-1:0] CANVAS_W_RST = 16'd1920;
  localparam logic [PIX_W-1:0] CANVAS_H_RST = 16'd1080;

  typedef enum logic [0:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rect_x;
    logic signed [DATA_W-1:0] rect_y;
    logic signed [DATA_W-1:0] rect_w;
    logic signed [DATA_W-1:0] rect_h;
    logic signed [DATA_W-1:0] m_xx;
    logic signed [DATA_W-1:0] m_xy;
    logic signed [DATA_W-1:0] m_yx;
    logic signed [DATA_W-1:0] m_yy;
    logic signed [DATA_W-1:0] m_tx;
    logic signed [DATA_W-1:0] m_ty;
    logic                     antialias;
  } srt_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_x;
    logic [PIX_W-1:0] out_y;
    logic [PIX_W-1:0] out_w;
    logic [PIX_W-1:0] out_h;
  } srt_out_t;

  typedef struct packed {
    reg_idx_t         reg_index;
    logic [PIX_W-1:0] wdata;
  } srt_cfg_t;

  // Clip result of one axis, in whole pixels.
  typedef struct packed {
    logic             hit;
    logic             aligned;
    logic [PIX_W-1:0] lo_px;
    logic [PIX_W-1:0] hi_px;
  } srt_axis_t;

endpackage

// ----- design/srt_chan_if.sv -----
interface srt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/srt_clip.sv -----
module srt_clip #(
  parameter int FRAC_BITS = srt_pkg::FRAC_BITS_DEF
) (
  input  logic signed [srt_pkg::SUM_W-1:0] lo,
  input  logic signed [srt_pkg::SUM_W-1:0] hi,
  input  logic        [srt_pkg::PIX_W-1:0] canvas,
  output srt_pkg::srt_axis_t               axis
);
  import srt_pkg::*;

  localparam int SH   = 2 * FRAC_BITS;
  localparam int PX_W = SUM_W - SH;
  localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << SH) - SUM_W'(1);

  logic signed [PX_W-1:0] fl;
  logic signed [PX_W-1:0] fh;
  logic signed [PX_W-1:0] ch;
  logic signed [PX_W-1:0] cs;
  logic                   lo_frac;
  logic                   hi_frac;
  logic                   lo_nonpos;
  logic                   hi_pos;

  // Arithmetic shift of the Q.(2F) value gives the floor in pixels.
  assign fl      = lo[SUM_W-1:SH];
  assign fh      = hi[SUM_W-1:SH];
  assign lo_frac = (lo & FRAC_MASK) != '0;
  assign hi_frac = (hi & FRAC_MASK) != '0;
  assign ch      = fh + PX_W'(hi_frac);
  assign cs      = {{(PX_W-PIX_W){1'b0}}, canvas};

  assign lo_nonpos = lo[SUM_W-1] || (lo == '0);
  assign hi_pos    = !hi[SUM_W-1] && (hi != '0);

  always_comb begin
    axis.hit     = (hi > lo) && hi_pos && (canvas != '0) && (fl < cs);
    axis.lo_px   = fl[PX_W-1] ? '0 : fl[PIX_W-1:0];
    axis.hi_px   = (ch > cs) ? canvas : ch[PIX_W-1:0];
    axis.aligned = (lo_nonpos || !lo_frac) && ((fh >= cs) || !hi_frac);
  end

endmodule

// ----- design/scissor_rect_transform.sv -----
// Maps a Q16.16 rectangle through a 2x3 affine matrix and returns the integer
// scissor box that covers it on the canvas. One transaction is accepted per
// clock as long as the result side takes transactions; each one passes
// through the six register stages (input, multiply, partial sum, bounding
// box, clip, output) in order. A stall on the result side fills pipeline
// bubbles first, so the input keeps accepting until every stage holds a
// transaction. The canvas size is written through the configuration channel
// (index 0 is width, index 1 is height, reset 1920 by 1080) and must only
// change while no transaction is in flight. Empty rectangles, boxes that miss
// the canvas and a zero canvas all give an all-zero result.
module scissor_rect_transform #(
  parameter int FRAC_BITS = srt_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  srt_chan_if.sink   in_ch,
  srt_chan_if.source out_ch,
  srt_chan_if.sink   cfg_ch
);
  import srt_pkg::*;

  localparam int NUM_STG = 6;
  localparam int OUT_STG = NUM_STG - 1;

  // Stage valid bits and per-stage advance strobes.
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] adv;
  logic               in_acc;

  logic [PIX_W-1:0] cw_r;
  logic [PIX_W-1:0] chh_r;

  // Stage 0: input register.
  srt_in_t in_r;

  // Stage 1: products. The corner sums are split so that each coefficient
  // multiplies the origin and the size separately.
  logic signed [PROD_W-1:0] p_xxx_r, p_wxx_r, p_yyx_r, p_hyx_r;
  logic signed [PROD_W-1:0] p_xxy_r, p_wxy_r, p_yyy_r, p_hyy_r;
  logic signed [PROD_W-1:0] p_xxx_nxt, p_wxx_nxt, p_yyx_nxt, p_hyx_nxt;
  logic signed [PROD_W-1:0] p_xxy_nxt, p_wxy_nxt, p_yyy_nxt, p_hyy_nxt;
  logic signed [DATA_W-1:0] tx1_r, ty1_r;
  logic                     aa1_r, empty1_r;

  // Stage 2: origin corner and the extreme offsets of the other corners.
  logic signed [SUM_W-1:0] base_x_r, base_y_r;
  logic signed [SUM_W-1:0] offlo_x_r, offhi_x_r, offlo_y_r, offhi_y_r;
  logic                    aa2_r, empty2_r;

  // Stage 3: bounding box in Q.(2F).
  logic signed [SUM_W-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic                    aa3_r, empty3_r;

  // Stage 4: per-axis clip.
  srt_axis_t ax_nxt, ay_nxt;
  srt_axis_t ax_r, ay_r;
  logic      aa4_r, empty4_r;

  // Stage 5: output register.
  srt_out_t out_r;
  srt_out_t out_nxt;

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    ext = SUM_W'(p);
  endfunction

  function automatic logic signed [SUM_W-1:0] neg_part(input logic signed [PROD_W-1:0] p);
    neg_part = p[PROD_W-1] ? SUM_W'(p) : '0;
  endfunction

  function automatic logic signed [SUM_W-1:0] pos_part(input logic signed [PROD_W-1:0] p);
    pos_part = p[PROD_W-1] ? '0 : SUM_W'(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control. A stage moves on when the next stage is empty or is moving
  // on itself, so a stall at the output only holds back stages that are full.
  // ---------------------------------------------------------------------------
  always_comb begin
    adv[OUT_STG] = vld_r[OUT_STG] && out_ch.ready;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      adv[i] = vld_r[i] && (!vld_r[i+1] || adv[i+1]);
    end
  end

  assign in_ch.ready = !vld_r[0] || adv[0];
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt[0] = in_acc || (vld_r[0] && !adv[0]);
    for (int i = 1; i < NUM_STG; i++) begin
      vld_nxt[i] = adv[i-1] || (vld_r[i] && !adv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers. The channel is always ready.
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= CANVAS_W_RST;
      chh_r <= CANVAS_H_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.reg_index)
        REG_CANVAS_WIDTH:  cw_r  <= cfg_ch.data.wdata;
        REG_CANVAS_HEIGHT: chh_r <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture the transaction.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_ch.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: eight signed 32x32 products. Since x' = x*m_xx + y*m_yx + tx, a
  // corner at x + w contributes w*m_xx on top of the origin corner, and the
  // same holds for each of the other terms.
  // ---------------------------------------------------------------------------
  assign p_xxx_nxt = in_r.rect_x * in_r.m_xx;
  assign p_wxx_nxt = in_r.rect_w * in_r.m_xx;
  assign p_yyx_nxt = in_r.rect_y * in_r.m_yx;
  assign p_hyx_nxt = in_r.rect_h * in_r.m_yx;
  assign p_xxy_nxt = in_r.rect_x * in_r.m_xy;
  assign p_wxy_nxt = in_r.rect_w * in_r.m_xy;
  assign p_yyy_nxt = in_r.rect_y * in_r.m_yy;
  assign p_hyy_nxt = in_r.rect_h * in_r.m_yy;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_xxx_r  <= p_xxx_nxt;
      p_wxx_r  <= p_wxx_nxt;
      p_yyx_r  <= p_yyx_nxt;
      p_hyx_r  <= p_hyx_nxt;
      p_xxy_r  <= p_xxy_nxt;
      p_wxy_r  <= p_wxy_nxt;
      p_yyy_r  <= p_yyy_nxt;
      p_hyy_r  <= p_hyy_nxt;
      tx1_r    <= in_r.m_tx;
      ty1_r    <= in_r.m_ty;
      aa1_r    <= in_r.antialias;
      // A rectangle with a width or height that is not positive is empty.
      empty1_r <= in_r.rect_w[DATA_W-1] || (in_r.rect_w == '0) ||
                  in_r.rect_h[DATA_W-1] || (in_r.rect_h == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the corner offsets choose independently between zero and the
  // size term, so the minimum over the four corners is the origin plus the
  // negative parts, and the maximum is the origin plus the positive parts.
  // The sums are kept exact; a mapped corner that would saturate a 64-bit
  // value lies far outside any canvas, so the clipped result is the same.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      base_x_r  <= ext(p_xxx_r) + ext(p_yyx_r) + (SUM_W'(tx1_r) <<< FRAC_BITS);
      base_y_r  <= ext(p_xxy_r) + ext(p_yyy_r) + (SUM_W'(ty1_r) <<< FRAC_BITS);
      offlo_x_r <= neg_part(p_wxx_r) + neg_part(p_hyx_r);
      offhi_x_r <= pos_part(p_wxx_r) + pos_part(p_hyx_r);
      offlo_y_r <= neg_part(p_wxy_r) + neg_part(p_hyy_r);
      offhi_y_r <= pos_part(p_wxy_r) + pos_part(p_hyy_r);
      aa2_r     <= aa1_r;
      empty2_r  <= empty1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: bounding box of the mapped corners.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      lo_x_r   <= base_x_r + offlo_x_r;
      hi_x_r   <= base_x_r + offhi_x_r;
      lo_y_r   <= base_y_r + offlo_y_r;
      hi_y_r   <= base_y_r + offhi_y_r;
      aa3_r    <= aa2_r;
      empty3_r <= empty2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: intersect each axis with the canvas and round outward.
  // ---------------------------------------------------------------------------
  srt_clip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_clip_x (
    .lo     (lo_x_r),
    .hi     (hi_x_r),
    .canvas (cw_r),
    .axis   (ax_nxt)
  );

  srt_clip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_clip_y (
    .lo     (lo_y_r),
    .hi     (hi_y_r),
    .canvas (chh_r),
    .axis   (ay_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      aa4_r    <= aa3_r;
      empty4_r <= empty3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: antialias growth and final clamp. A clipped box always has a
  // far edge above its origin, and growth only widens it, so the subtraction
  // cannot wrap. Growing stops at the canvas edges.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic             hit;
    logic             grow;
    logic [PIX_W-1:0] ox;
    logic [PIX_W-1:0] oy;
    logic [PIX_W-1:0] ex;
    logic [PIX_W-1:0] ey;

    hit  = !empty4_r && ax_r.hit && ay_r.hit;
    grow = aa4_r && !(ax_r.aligned && ay_r.aligned);
    ox   = (grow && (ax_r.lo_px != '0)) ? ax_r.lo_px - 1'b1 : ax_r.lo_px;
    oy   = (grow && (ay_r.lo_px != '0)) ? ay_r.lo_px - 1'b1 : ay_r.lo_px;
    ex   = (grow && (ax_r.hi_px != cw_r)) ? ax_r.hi_px + 1'b1 : ax_r.hi_px;
    ey   = (grow && (ay_r.hi_px != chh_r)) ? ay_r.hi_px + 1'b1 : ay_r.hi_px;

    if (hit) begin
      out_nxt.out_x = ox;
      out_nxt.out_y = oy;
      out_nxt.out_w = ex - ox;
      out_nxt.out_h = ey - oy;
    end else begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = vld_r[OUT_STG];
  assign out_ch.data  = out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Back pressure at the input only comes from a full pipeline that the
  // result side is stalling.
  a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> ((&vld_r) && !out_ch.ready))
    else $error("input stalled while the pipeline had room");

  // The scissor box stays inside the canvas horizontally.
  a_x_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_r.out_x} + {1'b0, out_r.out_w} <= {1'b0, cw_r}))
    else $error("scissor box exceeds canvas width");

  // The scissor box stays inside the canvas vertically.
  a_y_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_r.out_y} + {1'b0, out_r.out_h} <= {1'b0, chh_r}))
    else $error("scissor box exceeds canvas height");

  // A box with no area is reported as all zeros.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_r.out_w == '0) || (out_r.out_h == '0))) |->
    ((out_r.out_x == '0) && (out_r.out_y == '0) &&
     (out_r.out_w == '0) && (out_r.out_h == '0)))
    else $error("degenerate scissor box with nonzero fields");

endmodule
